[design/five_bar_scara_inverse_kinematics_core_defines.svh]
// Assertion macros used by fbsik_back
`ifndef FIVE_BAR_SCARA_INVERSE_KINEMATICS_CORE_DEFINES_SVH
`define FIVE_BAR_SCARA_INVERSE_KINEMATICS_CORE_DEFINES_SVH
`ifndef SYNTH
`define FBSIK_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FBSIK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FBSIK_ASSERT_IMP(label, clk, rst, ante, cons)
`define FBSIK_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[design/fbsik_pkg.sv]
package fbsik_pkg;

  localparam int ANGLE_ITERATIONS = 16;
  localparam int ITER_W = $clog2(ANGLE_ITERATIONS);

  localparam int LEN_W   = 16;
  localparam int SPR_W   = 32;
  localparam int POS_W   = 17;
  localparam int OFS_W   = 18;
  localparam int PEN_W   = 16;
  localparam int STEP_W  = 24;
  localparam int MUL_W   = 34;
  localparam int CORD_W  = 46;
  localparam int ANG_W   = 34;
  localparam int THETA_W = 36;

  localparam logic signed [ANG_W-1:0]   HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [THETA_W-1:0] PI_Q30      = 36'sd3373259426;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_PROXIMAL = 2'd0;
  localparam reg_idx_t REG_DISTAL   = 2'd1;
  localparam reg_idx_t REG_HALF_GAP = 2'd2;
  localparam reg_idx_t REG_SPR      = 2'd3;

  typedef struct packed {
    logic signed [OFS_W-1:0] dx1;
    logic signed [OFS_W-1:0] dx2;
    logic signed [POS_W-1:0] dy;
    logic signed [PEN_W-1:0] pen;
  } item_t;

  typedef struct packed {
    logic                     start;
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
  } cord_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [ANG_W-1:0] z;
  } cord_rsp_t;

  // atan(2^-i) in Q30, truncated; entries 27 to 30 are rounded up
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd843314856;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043836;
      5'd3:  r = 30'd133525158;
      5'd4:  r = 30'd67021686;
      5'd5:  r = 30'd33543515;
      5'd6:  r = 30'd16775850;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194282;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048575;
      5'd11: r = 30'd524287;
      5'd12: r = 30'd262143;
      5'd13: r = 30'd131071;
      5'd14: r = 30'd65535;
      5'd15: r = 30'd32767;
      5'd16: r = 30'd16383;
      5'd17: r = 30'd8191;
      5'd18: r = 30'd4095;
      5'd19: r = 30'd2047;
      5'd20: r = 30'd1023;
      5'd21: r = 30'd511;
      5'd22: r = 30'd255;
      5'd23: r = 30'd127;
      5'd24: r = 30'd63;
      5'd25: r = 30'd31;
      5'd26: r = 30'd15;
      5'd27: r = 30'd8;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

[design/fbsik_front.sv]
module fbsik_front import fbsik_pkg::*; (
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [POS_W-1:0] x_pos,
  input  logic signed [POS_W-1:0] y_pos,
  input  logic signed [PEN_W-1:0] pen_height_in,
  input  logic [LEN_W-1:0]        half_gap,
  input  logic                    q_full,
  output logic                    push,
  output item_t                   push_item
);

  logic signed [OFS_W-1:0] gap_s;
  logic signed [OFS_W-1:0] x_s;

  assign gap_s = OFS_W'($signed({1'b0, half_gap}));
  assign x_s   = OFS_W'(x_pos);

  // offsets from the left and right shoulder pivots
  assign push_item.dx1 = gap_s + x_s;
  assign push_item.dx2 = gap_s - x_s;
  assign push_item.dy  = y_pos;
  assign push_item.pen = pen_height_in;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

endmodule

[design/fbsik_queue.sv]
module fbsik_queue import fbsik_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  empty,
  output logic  full
);

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = count == QCNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/fbsik_cordic.sv]
module fbsik_cordic import fbsik_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cord_req_t req,
  output cord_rsp_t rsp
);

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_NORM = 3'b010,
    C_ITER = 3'b100
  } cstate_t;

  cstate_t                  state;
  logic signed [CORD_W-1:0] x;
  logic signed [CORD_W-1:0] y;
  logic signed [ANG_W-1:0]  z;
  logic [ITER_W-1:0]        it;
  logic                     done;

  logic [CORD_W-1:0]        ax;
  logic [CORD_W-1:0]        ay;
  logic                     below40;
  logic                     below32;
  logic signed [CORD_W-1:0] xs;
  logic signed [CORD_W-1:0] ys;
  logic signed [ANG_W-1:0]  step_ang;

  assign ax       = x[CORD_W-1] ? -x : x;
  assign ay       = y[CORD_W-1] ? -y : y;
  assign below40  = (ax[CORD_W-1:40] == '0) && (ay[CORD_W-1:40] == '0);
  assign below32  = (ax[CORD_W-1:32] == '0) && (ay[CORD_W-1:32] == '0);
  assign xs       = x >>> it;
  assign ys       = y >>> it;
  assign step_ang = $signed({{(ANG_W-30){1'b0}}, atan_q30(5'(it))});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (req.start) begin
            x  <= req.x;
            y  <= req.y;
            z  <= '0;
            it <= '0;
            if (req.x == '0 && req.y == '0) begin
              done <= 1'b1;
            end else begin
              state <= C_NORM;
            end
          end
        end
        C_NORM: begin
          if (below40) begin
            if (below32) begin
              x <= x <<< 8;
              y <= y <<< 8;
            end else begin
              x <= x <<< 1;
              y <= y <<< 1;
            end
          end else begin
            // fold into the right half-plane
            if (x[CORD_W-1]) begin
              if (!y[CORD_W-1]) begin
                x <= y;
                y <= -x;
                z <= HALF_PI_Q30;
              end else begin
                x <= -y;
                y <= x;
                z <= -HALF_PI_Q30;
              end
            end
            state <= C_ITER;
          end
        end
        C_ITER: begin
          if (y > 0) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + step_ang;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - step_ang;
          end
          if (it == ITER_W'(ANGLE_ITERATIONS - 1)) begin
            done  <= 1'b1;
            state <= C_IDLE;
          end else begin
            it <= it + 1'b1;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  assign rsp.busy = state != C_IDLE;
  assign rsp.done = done;
  assign rsp.z    = z;

endmodule

[design/fbsik_back.sv]
`include "five_bar_scara_inverse_kinematics_core_defines.svh"

module fbsik_back import fbsik_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [LEN_W-1:0]         l1,
  input  logic [LEN_W-1:0]         l2,
  input  logic [SPR_W-1:0]         spr,
  input  item_t                    head,
  input  logic                     q_empty,
  output logic                     pop,
  output cord_req_t                cord_req,
  input  cord_rsp_t                cord_rsp,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [STEP_W-1:0] shoulder_steps,
  output logic signed [STEP_W-1:0] elbow_steps,
  output logic signed [PEN_W-1:0]  pen_height_out,
  output logic                     out_of_reach
);

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_SQ_L1   = 16'h0002,
    S_SQ_L2   = 16'h0004,
    S_SQ_SUM  = 16'h0008,
    S_SQ_DIF  = 16'h0010,
    S_SQ_DX   = 16'h0020,
    S_SQ_DY   = 16'h0040,
    S_CHECK   = 16'h0080,
    S_MUL_AB  = 16'h0100,
    S_SQRT    = 16'h0200,
    S_CORD_IN = 16'h0400,
    S_CORD_BR = 16'h0800,
    S_MUL_HI  = 16'h1000,
    S_MUL_LO  = 16'h2000,
    S_ROUND   = 16'h4000,
    S_DONE    = 16'h8000
  } bstate_t;

  bstate_t                   state;
  item_t                     item;
  logic                      arm;
  logic                      sel;
  logic                      bad;
  logic                      cord_wait;
  logic [31:0]               l1sq;
  logic [31:0]               l2sq;
  logic [31:0]               dif2;
  logic [33:0]               sum2;
  logic [33:0]               dxsq;
  logic [34:0]               d;
  logic [31:0]               a_r;
  logic [31:0]               b_r;
  logic signed [36:0]        num;
  logic [63:0]               ab;
  logic [31:0]               root;
  logic [35:0]               rem;
  logic [4:0]                cnt;
  logic signed [ANG_W-1:0]   inner;
  logic signed [THETA_W-1:0] theta1;
  logic signed [THETA_W-1:0] theta2;
  logic [48:0]               ph;
  logic [48:0]               pl;
  logic signed [STEP_W-1:0]  shoulder_r;
  logic signed [STEP_W-1:0]  elbow_r;

  logic signed [MUL_W-1:0]   ma;
  logic signed [MUL_W-1:0]   mb;
  logic signed [2*MUL_W-1:0] mp;
  logic [LEN_W:0]            len_sum;
  logic signed [LEN_W:0]     len_dif;
  logic signed [OFS_W-1:0]   dx_cur;
  logic signed [36:0]        sa;
  logic signed [36:0]        sb;
  logic signed [36:0]        v;
  logic signed [36:0]        vadj;
  logic                      unreach;
  logic [35:0]               rem_sh;
  logic [35:0]               trial;
  logic signed [THETA_W-1:0] tcur;
  logic signed [THETA_W-1:0] tmag;
  logic [49:0]               q;
  logic [49:0]               qr;
  logic [STEP_W-1:0]         smag;
  logic signed [STEP_W-1:0]  sres;
  logic                      load_out;

  assign len_sum = {1'b0, l1} + {1'b0, l2};
  assign len_dif = $signed({1'b0, l1}) - $signed({1'b0, l2});
  assign dx_cur  = arm ? item.dx2 : item.dx1;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_SQ_L1: begin
        ma = MUL_W'($signed({1'b0, l1}));
        mb = ma;
      end
      S_SQ_L2: begin
        ma = MUL_W'($signed({1'b0, l2}));
        mb = ma;
      end
      S_SQ_SUM: begin
        ma = MUL_W'($signed({1'b0, len_sum}));
        mb = ma;
      end
      S_SQ_DIF: begin
        ma = MUL_W'(len_dif);
        mb = ma;
      end
      S_SQ_DX: begin
        ma = MUL_W'(dx_cur);
        mb = ma;
      end
      S_SQ_DY: begin
        ma = MUL_W'(item.dy);
        mb = ma;
      end
      S_MUL_AB: begin
        ma = MUL_W'($signed({1'b0, a_r}));
        mb = MUL_W'($signed({1'b0, b_r}));
      end
      S_MUL_HI: begin
        ma = MUL_W'($signed({1'b0, tmag[32:0]}));
        mb = MUL_W'($signed({1'b0, spr[31:16]}));
      end
      S_MUL_LO: begin
        ma = MUL_W'($signed({1'b0, tmag[32:0]}));
        mb = MUL_W'($signed({1'b0, spr[15:0]}));
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mp = ma * mb;

  assign sa      = $signed({3'b0, sum2}) - $signed({2'b0, d});
  assign sb      = $signed({2'b0, d}) - $signed({5'b0, dif2});
  assign v       = $signed({5'b0, l1sq}) + $signed({2'b0, d}) - $signed({5'b0, l2sq});
  assign vadj    = v + (v[36] ? 37'sd7 : 37'sd0);
  assign unreach = (l1 == '0) || (d == '0) || sa[36] || sb[36];

  assign rem_sh = {rem[33:0], ab[63:62]};
  assign trial  = {2'b0, root, 2'b01};

  assign tcur = sel ? theta1 : theta2;
  assign tmag = tcur[THETA_W-1] ? -tcur : tcur;
  assign q    = {1'b0, ph} + {17'b0, pl[48:16]};
  assign qr   = q + 50'd536870912;
  assign smag = {4'b0, qr[49:30]};
  assign sres = tcur[THETA_W-1] ? -$signed(smag) : $signed(smag);

  assign pop      = (state == S_IDLE) && !q_empty;
  assign load_out = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    cord_req.start = ((state == S_CORD_IN) || (state == S_CORD_BR)) && !cord_wait;
    if (state == S_CORD_IN) begin
      cord_req.x = CORD_W'(num);
      cord_req.y = CORD_W'($signed({1'b0, root}));
    end else begin
      cord_req.x = CORD_W'(dx_cur);
      cord_req.y = CORD_W'(item.dy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cord_wait <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cord_req.start) begin
        cord_wait <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            item  <= head;
            arm   <= 1'b0;
            bad   <= 1'b0;
            state <= S_SQ_L1;
          end
        end
        S_SQ_L1: begin
          l1sq  <= mp[31:0];
          state <= S_SQ_L2;
        end
        S_SQ_L2: begin
          l2sq  <= mp[31:0];
          state <= S_SQ_SUM;
        end
        S_SQ_SUM: begin
          sum2  <= mp[33:0];
          state <= S_SQ_DIF;
        end
        S_SQ_DIF: begin
          dif2  <= mp[31:0];
          state <= S_SQ_DX;
        end
        S_SQ_DX: begin
          dxsq  <= mp[33:0];
          state <= S_SQ_DY;
        end
        S_SQ_DY: begin
          d     <= {1'b0, dxsq} + {2'b0, mp[32:0]};
          state <= S_CHECK;
        end
        S_CHECK: begin
          a_r <= sa[34:3];
          b_r <= sb[34:3];
          num <= vadj >>> 3;
          if (unreach) begin
            bad   <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_MUL_AB;
          end
        end
        S_MUL_AB: begin
          ab    <= mp[63:0];
          root  <= '0;
          rem   <= '0;
          cnt   <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[30:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[30:0], 1'b0};
          end
          ab  <= ab << 2;
          cnt <= cnt + 1'b1;
          if (cnt == 5'd31) begin
            state <= S_CORD_IN;
          end
        end
        S_CORD_IN: begin
          if (cord_rsp.done) begin
            inner     <= cord_rsp.z;
            cord_wait <= 1'b0;
            state     <= S_CORD_BR;
          end
        end
        S_CORD_BR: begin
          if (cord_rsp.done) begin
            cord_wait <= 1'b0;
            if (!arm) begin
              theta1 <= THETA_W'(cord_rsp.z) + THETA_W'(inner);
              arm    <= 1'b1;
              state  <= S_SQ_DX;
            end else begin
              theta2 <= PI_Q30 - THETA_W'(cord_rsp.z) - THETA_W'(inner);
              sel    <= 1'b0;
              state  <= S_MUL_HI;
            end
          end
        end
        S_MUL_HI: begin
          ph    <= mp[48:0];
          state <= S_MUL_LO;
        end
        S_MUL_LO: begin
          pl    <= mp[48:0];
          state <= S_ROUND;
        end
        S_ROUND: begin
          if (!sel) begin
            shoulder_r <= sres;
            sel        <= 1'b1;
            state      <= S_MUL_HI;
          end else begin
            elbow_r <= sres;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            shoulder_steps <= bad ? '0 : shoulder_r;
            elbow_steps    <= bad ? '0 : elbow_r;
            pen_height_out <= item.pen;
            out_of_reach   <= bad;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FBSIK_ASSERT_IMP(a_oor_zero, clk, rst, out_valid && out_of_reach, shoulder_steps == '0 && elbow_steps == '0)
  `FBSIK_ASSERT_IMP(a_cord_start_idle, clk, rst, cord_req.start, !cord_rsp.busy)
  `FBSIK_ASSERT_NEXT(a_load_done, clk, rst, load_out, out_valid && state == S_IDLE)

endmodule

[design/five_bar_scara_inverse_kinematics_core.sv]
// The solve time is set by the shared 32-step square root and four CORDIC runs (two per arm)
//   on one solver; the back end solves one item at a time, and unreachable targets finish early.
// A two-entry queue and an output register keep both channels moving independently.
// Reset (rst, synchronous): clears control state and loads the default geometry registers.
module five_bar_scara_inverse_kinematics_core import fbsik_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [POS_W-1:0]  x_pos,
  input  logic signed [POS_W-1:0]  y_pos,
  input  logic signed [PEN_W-1:0]  pen_height_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [STEP_W-1:0] shoulder_steps,
  output logic signed [STEP_W-1:0] elbow_steps,
  output logic signed [PEN_W-1:0]  pen_height_out,
  output logic                     out_of_reach
);

  logic [LEN_W-1:0] proximal_arm_len;
  logic [LEN_W-1:0] distal_arm_len;
  logic [LEN_W-1:0] base_half_gap;
  logic [SPR_W-1:0] steps_per_radian;
  reg_idx_t         ridx;

  logic      push;
  item_t     push_item;
  logic      pop;
  item_t     head;
  logic      q_empty;
  logic      q_full;
  cord_req_t cord_req;
  cord_rsp_t cord_rsp;

  assign pready = 1'b1;
  assign ridx   = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      proximal_arm_len <= 16'd20480;
      distal_arm_len   <= 16'd25600;
      base_half_gap    <= 16'd8960;
      steps_per_radian <= 32'd65536;
    end else if (psel && penable && pwrite && pready) begin
      unique case (ridx)
        REG_PROXIMAL: proximal_arm_len <= pwdata[LEN_W-1:0];
        REG_DISTAL:   distal_arm_len   <= pwdata[LEN_W-1:0];
        REG_HALF_GAP: base_half_gap    <= pwdata[LEN_W-1:0];
        REG_SPR:      steps_per_radian <= pwdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_PROXIMAL: prdata = {16'b0, proximal_arm_len};
      REG_DISTAL:   prdata = {16'b0, distal_arm_len};
      REG_HALF_GAP: prdata = {16'b0, base_half_gap};
      REG_SPR:      prdata = steps_per_radian;
      default:      prdata = '0;
    endcase
  end

  fbsik_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .x_pos         (x_pos),
    .y_pos         (y_pos),
    .pen_height_in (pen_height_in),
    .half_gap      (base_half_gap),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item)
  );

  fbsik_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  fbsik_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (cord_req),
    .rsp (cord_rsp)
  );

  fbsik_back u_back (
    .clk            (clk),
    .rst            (rst),
    .l1             (proximal_arm_len),
    .l2             (distal_arm_len),
    .spr            (steps_per_radian),
    .head           (head),
    .q_empty        (q_empty),
    .pop            (pop),
    .cord_req       (cord_req),
    .cord_rsp       (cord_rsp),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .shoulder_steps (shoulder_steps),
    .elbow_steps    (elbow_steps),
    .pen_height_out (pen_height_out),
    .out_of_reach   (out_of_reach)
  );

endmodule
